[rtl/erp_pkg.sv]
// Package for the e-paper refresh policy block: request and refresh codes,
// configuration and counter structs, saturating counter helper. No dependencies.
package erp_pkg;

   localparam int unsigned COUNT_BITS = 6;
   localparam int unsigned BOOT_BITS  = 4;
   localparam int unsigned CSR_DATA_BITS  = 6;
   localparam int unsigned CSR_INDEX_BITS = 2;

   localparam logic [COUNT_BITS-1:0] COUNT_MAX = 6'd63;

   // Configuration register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_PARTIAL_ENABLE  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MAIN_PERIOD     = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_OTHER_PERIOD    = 2'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_BOOT_FULL_COUNT = 2'd3;

   // Reset values of the configuration registers
   localparam logic [COUNT_BITS-1:0] MAIN_PERIOD_RESET     = 6'd11;
   localparam logic [COUNT_BITS-1:0] OTHER_PERIOD_RESET    = 6'd6;
   localparam logic [BOOT_BITS-1:0]  BOOT_FULL_COUNT_RESET = 4'd3;

   typedef enum logic [2:0] {
      REQ_SHOW_FRAME  = 3'd0,
      REQ_PAGE_SWITCH = 3'd1,
      REQ_WAKE_RESET  = 3'd2,
      REQ_CLEAR_MAIN  = 3'd3,
      REQ_PANEL_STUCK = 3'd4
   } req_code_type;

   typedef enum logic [1:0] {
      KIND_NONE    = 2'd0,
      KIND_FULL    = 2'd1,
      KIND_PARTIAL = 2'd2
   } kind_type;

   typedef struct packed {
      logic                  partial_enable;
      logic [COUNT_BITS-1:0] main_period;
      logic [COUNT_BITS-1:0] other_period;
      logic [BOOT_BITS-1:0]  boot_full_count;
   } cfg_type;

   typedef struct packed {
      logic [BOOT_BITS-1:0]  boot_done;
      logic [COUNT_BITS-1:0] main_pos;
      logic [COUNT_BITS-1:0] switch_pos;
   } count_type;

   // Advance a counter, stopping at the top value
   function automatic logic [COUNT_BITS-1:0] bump(input logic [COUNT_BITS-1:0] v);
      return (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
   endfunction

endpackage

[rtl/erp_decide.sv]
// Refresh decision logic: next counter state and refresh kind for one item.
// Depends on erp_pkg.
module erp_decide #(
   parameter int unsigned SCREEN_ID_BITS = 4
) (
   input  erp_pkg::cfg_type             cfg,
   input  erp_pkg::count_type           cnt_cur,
   input  logic [SCREEN_ID_BITS-1:0]    prev_screen_cur,
   input  logic [2:0]                   req_type,
   input  logic [SCREEN_ID_BITS-1:0]    screen_id,
   output erp_pkg::count_type           cnt_next,
   output logic [SCREEN_ID_BITS-1:0]    prev_screen_next,
   output erp_pkg::kind_type            kind
);
   import erp_pkg::*;

   logic                  is_main;
   logic [COUNT_BITS-1:0] period;
   logic [COUNT_BITS-1:0] pos;
   logic [COUNT_BITS-1:0] main_bumped;
   logic                  in_boot;
   logic                  changed;

   assign is_main     = (screen_id == '0);
   assign period      = is_main ? cfg.main_period : cfg.other_period;
   assign main_bumped = bump(cnt_cur.main_pos);
   assign in_boot     = (cnt_cur.boot_done < cfg.boot_full_count);
   assign changed     = (screen_id != prev_screen_cur);

   // Counter seen by the show-frame decision: the main counter advances first on a repeat
   always_comb begin
      if (is_main && !changed) begin
         pos = main_bumped;
      end else if (is_main) begin
         pos = cnt_cur.main_pos;
      end else begin
         pos = cnt_cur.switch_pos;
      end
   end

   always_comb begin
      cnt_next         = cnt_cur;
      prev_screen_next = prev_screen_cur;
      kind             = KIND_NONE;
      case (req_code_type'(req_type))
         REQ_SHOW_FRAME: begin
            if (in_boot) begin
               cnt_next.boot_done = cnt_cur.boot_done + 1'b1;
               cnt_next.main_pos  = '0;
               prev_screen_next   = screen_id;
               kind               = KIND_FULL;
            end else begin
               prev_screen_next = screen_id;
               if (is_main && !changed) begin
                  cnt_next.main_pos = main_bumped;
               end
               if (pos >= period || !cfg.partial_enable) begin
                  // full refresh: drop the counter of the screen shown
                  kind = KIND_FULL;
                  if (is_main) begin
                     cnt_next.main_pos = '0;
                  end else begin
                     cnt_next.switch_pos = '0;
                  end
               end else begin
                  kind = KIND_PARTIAL;
               end
            end
         end
         REQ_PAGE_SWITCH: begin
            if (is_main) begin
               cnt_next.main_pos = (cnt_cur.main_pos >= cfg.main_period) ?
                                   COUNT_BITS'(1) : main_bumped;
            end else begin
               cnt_next.switch_pos = (cnt_cur.switch_pos >= cfg.other_period) ?
                                     COUNT_BITS'(1) : bump(cnt_cur.switch_pos);
            end
         end
         REQ_WAKE_RESET: begin
            cnt_next.main_pos = '0;
            prev_screen_next  = '0;
         end
         REQ_CLEAR_MAIN: begin
            cnt_next.main_pos = '0;
         end
         REQ_PANEL_STUCK: begin
            cnt_next.main_pos   = '0;
            cnt_next.switch_pos = '0;
            kind                = KIND_FULL;
         end
         default: begin
            kind = KIND_NONE;
         end
      endcase
   end

endmodule

[rtl/epaper_refresh_policy.sv]
// Top level of the e-paper refresh policy block: handshakes, configuration
// registers, policy state and result register. Depends on erp_pkg, erp_decide.
//
// Each accepted request item yields exactly one result item, the refresh kind
// (none, full or partial), in the result register the next cycle. The block
// takes one item per clock unless stalled: req_ready is high whenever the
// result register is empty or its item is taken in the same cycle; the rate
// is set by the combinational decision path between the policy state
// registers and the result register. The first boot_full_count frames after
// reset are full; the main screen and the other screens as a group each have
// a counter with its own period that forces a full refresh; partial refreshes
// appear only while partial_enable is set. Configuration registers are
// written through csr_wr_en / csr_index / csr_wdata, take effect on the next
// item, and should be changed only while no item is in flight.
module epaper_refresh_policy #(
   parameter int unsigned SCREEN_ID_BITS = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  csr_wr_en,
   input  logic [erp_pkg::CSR_INDEX_BITS-1:0]    csr_index,
   input  logic [erp_pkg::CSR_DATA_BITS-1:0]     csr_wdata,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic [2:0]                            req_type,
   input  logic [SCREEN_ID_BITS-1:0]             req_screen_id,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic [1:0]                            rsp_refresh_kind
);
   import erp_pkg::*;

   cfg_type                   cfg_ff;
   count_type                 cnt_ff;
   count_type                 cnt_in;
   logic [SCREEN_ID_BITS-1:0] prev_screen_ff;
   logic [SCREEN_ID_BITS-1:0] prev_screen_in;
   kind_type                  kind_in;
   logic                      rsp_valid_ff;
   logic [1:0]                rsp_kind_ff;
   logic                      req_fire;

   // Take a new item whenever the result slot is free or drains this cycle
   assign req_ready = !rsp_valid_ff || rsp_ready;
   assign req_fire  = req_valid && req_ready;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.partial_enable  <= 1'b0;
         cfg_ff.main_period     <= MAIN_PERIOD_RESET;
         cfg_ff.other_period    <= OTHER_PERIOD_RESET;
         cfg_ff.boot_full_count <= BOOT_FULL_COUNT_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_PARTIAL_ENABLE:  cfg_ff.partial_enable  <= csr_wdata[0];
            CSR_MAIN_PERIOD:     cfg_ff.main_period     <= csr_wdata[COUNT_BITS-1:0];
            CSR_OTHER_PERIOD:    cfg_ff.other_period    <= csr_wdata[COUNT_BITS-1:0];
            CSR_BOOT_FULL_COUNT: cfg_ff.boot_full_count <= csr_wdata[BOOT_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   erp_decide #(
      .SCREEN_ID_BITS (SCREEN_ID_BITS)
   ) u_decide (
      .cfg              (cfg_ff),
      .cnt_cur          (cnt_ff),
      .prev_screen_cur  (prev_screen_ff),
      .req_type         (req_type),
      .screen_id        (req_screen_id),
      .cnt_next         (cnt_in),
      .prev_screen_next (prev_screen_in),
      .kind             (kind_in)
   );

   // Policy state: advance only on an accepted item
   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff         <= '0;
         prev_screen_ff <= '0;
      end else if (req_fire) begin
         cnt_ff         <= cnt_in;
         prev_screen_ff <= prev_screen_in;
      end
   end

   // Result register: load on accept, drop once the consumer takes it
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_fire) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rsp_kind_ff <= kind_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_refresh_kind = rsp_kind_ff;

endmodule

[rtl/erp_checker.sv]
// Port-level checker for the e-paper refresh policy block, bound to the top.
// Depends on erp_pkg and epaper_refresh_policy.
module erp_checker #(
   parameter int unsigned SCREEN_ID_BITS = 4
) (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_valid,
   input logic                      req_ready,
   input logic [2:0]                req_type,
   input logic [SCREEN_ID_BITS-1:0] req_screen_id,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input logic [1:0]                rsp_refresh_kind
);
   import erp_pkg::*;

   // A held result keeps its value until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_refresh_kind))
      else $error("result changed while stalled");

   // Every accepted item produces a result in the next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> rsp_valid)
      else $error("accepted item produced no result");

   // An empty result slot never blocks the input
   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with empty result slot");

   // Panel stuck always asks for a full retry
   a_stuck_full: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type == REQ_PANEL_STUCK
      |=> rsp_refresh_kind == KIND_FULL)
      else $error("panel stuck did not give full refresh");

   // Page switches and other events apart from show frame and panel stuck never refresh
   a_switch_none: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_type != REQ_SHOW_FRAME && req_type != REQ_PANEL_STUCK
      |=> rsp_refresh_kind == KIND_NONE)
      else $error("non-frame event caused a refresh");

endmodule

bind epaper_refresh_policy erp_checker #(
   .SCREEN_ID_BITS (SCREEN_ID_BITS)
) u_erp_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .req_type         (req_type),
   .req_screen_id    (req_screen_id),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_refresh_kind (rsp_refresh_kind)
);
